[src/pdfsu_pkg.sv]
// Package with the shared types and character constants of the PDF string decoder.
package pdfsu_pkg;

  // Parser mode; the unused code acts as closed.
  typedef enum logic [1:0] {
    MODE_CLOSED = 2'd0,
    MODE_LIT    = 2'd1,
    MODE_HEX    = 2'd2
  } mode_e;

  // Escape progress inside a literal string; unused codes act as no escape.
  typedef enum logic [2:0] {
    ESC_NONE = 3'd0,
    ESC_BSL  = 3'd1,
    ESC_CR   = 3'd2,
    ESC_OCT1 = 3'd3,
    ESC_OCT2 = 3'd4
  } esc_e;

  typedef enum logic [0:0] {
    KIND_DATA = 1'b0,
    KIND_END  = 1'b1
  } kind_e;

  localparam int unsigned MaxRes = 3;
  localparam int unsigned QueueDepth = 2;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] value;
  } result_t;

  // All results caused by one input word, lowest index first.
  typedef struct packed {
    logic [1:0]             cnt;
    result_t [MaxRes-1:0]   res;
  } bundle_t;

  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_BSL    = 8'h5C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_SEVEN  = 8'h37;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UF     = 8'h46;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LF_    = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_FF     = 8'h0C;

endpackage

[src/pdfsu_front.sv]
// Front end: holds the parser state and turns each byte into a bundle of results.
module pdfsu_front #(
  parameter int unsigned DEPTH_BITS = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [7:0]          data_byte_i,
  input  logic                func_i,
  input  logic                first_i,
  input  logic                last_i,
  output logic                push_o,
  output pdfsu_pkg::bundle_t  bundle_o
);

  pdfsu_pkg::mode_e        mode_q, mode_d;
  logic [DEPTH_BITS-1:0]   depth_q, depth_d;
  pdfsu_pkg::esc_e         esc_q, esc_d;
  logic [7:0]              oct_q, oct_d;
  logic [3:0]              hi_q, hi_d;
  logic                    pend_q, pend_d;

  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [7:0] t;
    begin
      t = 8'h00;
      if (c inside {[pdfsu_pkg::CH_ZERO:pdfsu_pkg::CH_NINE]}) begin
        t = c - pdfsu_pkg::CH_ZERO;
      end else if (c inside {[pdfsu_pkg::CH_UA:pdfsu_pkg::CH_UF]}) begin
        t = c - pdfsu_pkg::CH_UA + 8'd10;
      end else if (c inside {[pdfsu_pkg::CH_LA:pdfsu_pkg::CH_LF_]}) begin
        t = c - pdfsu_pkg::CH_LA + 8'd10;
      end
      return t[3:0];
    end
  endfunction

  always_comb begin
    logic [1:0]         n;
    logic               do_plain;
    logic [7:0]         c;
    pdfsu_pkg::bundle_t b;

    c        = data_byte_i;
    n        = 2'd0;
    do_plain = 1'b0;
    b        = '0;
    mode_d   = mode_q;
    depth_d  = depth_q;
    esc_d    = esc_q;
    oct_d    = oct_q;
    hi_d     = hi_q;
    pend_d   = pend_q;

    if (first_i) begin
      esc_d  = pdfsu_pkg::ESC_NONE;
      oct_d  = 8'h00;
      hi_d   = 4'h0;
      pend_d = 1'b0;
      if (func_i) begin
        mode_d  = pdfsu_pkg::MODE_HEX;
        depth_d = '0;
      end else begin
        mode_d  = pdfsu_pkg::MODE_LIT;
        depth_d = DEPTH_BITS'(1);
      end
    end

    if (mode_d == pdfsu_pkg::MODE_LIT) begin
      case (esc_d)
        pdfsu_pkg::ESC_BSL: begin
          esc_d = pdfsu_pkg::ESC_NONE;
          case (c)
            pdfsu_pkg::CH_N: begin
              b.res[n] = '{kind: pdfsu_pkg::KIND_DATA, value: pdfsu_pkg::CH_LF}; n = n + 2'd1;
            end
            pdfsu_pkg::CH_R: begin
              b.res[n] = '{kind: pdfsu_pkg::KIND_DATA, value: pdfsu_pkg::CH_CR}; n = n + 2'd1;
            end
            pdfsu_pkg::CH_T: begin
              b.res[n] = '{kind: pdfsu_pkg::KIND_DATA, value: pdfsu_pkg::CH_TAB}; n = n + 2'd1;
            end
            pdfsu_pkg::CH_B: begin
              b.res[n] = '{kind: pdfsu_pkg::KIND_DATA, value: pdfsu_pkg::CH_BS}; n = n + 2'd1;
            end
            pdfsu_pkg::CH_LF_: begin
              b.res[n] = '{kind: pdfsu_pkg::KIND_DATA, value: pdfsu_pkg::CH_FF}; n = n + 2'd1;
            end
            pdfsu_pkg::CH_LF: begin
            end
            pdfsu_pkg::CH_CR: begin
              esc_d = pdfsu_pkg::ESC_CR;
            end
            default: begin
              if (c inside {[pdfsu_pkg::CH_ZERO:pdfsu_pkg::CH_SEVEN]}) begin
                oct_d = {5'b0, c[2:0]};
                esc_d = pdfsu_pkg::ESC_OCT1;
              end else begin
                b.res[n] = '{kind: pdfsu_pkg::KIND_DATA, value: c}; n = n + 2'd1;
              end
            end
          endcase
        end
        pdfsu_pkg::ESC_CR: begin
          esc_d    = pdfsu_pkg::ESC_NONE;
          do_plain = (c != pdfsu_pkg::CH_LF);
        end
        pdfsu_pkg::ESC_OCT1, pdfsu_pkg::ESC_OCT2: begin
          if (c inside {[pdfsu_pkg::CH_ZERO:pdfsu_pkg::CH_SEVEN]}) begin
            oct_d = {oct_d[4:0], c[2:0]};
            if (esc_d == pdfsu_pkg::ESC_OCT1) begin
              esc_d = pdfsu_pkg::ESC_OCT2;
            end else begin
              esc_d = pdfsu_pkg::ESC_NONE;
              b.res[n] = '{kind: pdfsu_pkg::KIND_DATA, value: oct_d}; n = n + 2'd1;
            end
          end else begin
            esc_d    = pdfsu_pkg::ESC_NONE;
            b.res[n] = '{kind: pdfsu_pkg::KIND_DATA, value: oct_d}; n = n + 2'd1;
            do_plain = 1'b1;
          end
        end
        default: begin
          esc_d    = pdfsu_pkg::ESC_NONE;
          do_plain = 1'b1;
        end
      endcase

      // Ordinary literal byte: backslash, nesting parens or plain data.
      if (do_plain) begin
        if (c == pdfsu_pkg::CH_BSL) begin
          esc_d = pdfsu_pkg::ESC_BSL;
        end else if (c == pdfsu_pkg::CH_LPAREN) begin
          if (depth_d != '1) depth_d = depth_d + DEPTH_BITS'(1);
          b.res[n] = '{kind: pdfsu_pkg::KIND_DATA, value: c}; n = n + 2'd1;
        end else if (c == pdfsu_pkg::CH_RPAREN) begin
          if (depth_d != '0) depth_d = depth_d - DEPTH_BITS'(1);
          if (depth_d != '0) begin
            b.res[n] = '{kind: pdfsu_pkg::KIND_DATA, value: c}; n = n + 2'd1;
          end else begin
            b.res[n] = '{kind: pdfsu_pkg::KIND_END, value: 8'h00}; n = n + 2'd1;
            mode_d = pdfsu_pkg::MODE_CLOSED;
            depth_d = '0;
            esc_d  = pdfsu_pkg::ESC_NONE;
            oct_d  = 8'h00;
            hi_d   = 4'h0;
            pend_d = 1'b0;
          end
        end else begin
          b.res[n] = '{kind: pdfsu_pkg::KIND_DATA, value: c}; n = n + 2'd1;
        end
      end
    end else if (mode_d == pdfsu_pkg::MODE_HEX) begin
      if (c == pdfsu_pkg::CH_GT) begin
        if (pend_d) begin
          b.res[n] = '{kind: pdfsu_pkg::KIND_DATA, value: {hi_d, 4'h0}}; n = n + 2'd1;
        end
        b.res[n] = '{kind: pdfsu_pkg::KIND_END, value: 8'h00}; n = n + 2'd1;
        mode_d  = pdfsu_pkg::MODE_CLOSED;
        depth_d = '0;
        esc_d   = pdfsu_pkg::ESC_NONE;
        oct_d   = 8'h00;
        hi_d    = 4'h0;
        pend_d  = 1'b0;
      end else if (c == pdfsu_pkg::CH_SPACE || c == pdfsu_pkg::CH_TAB ||
                   c == pdfsu_pkg::CH_CR || c == pdfsu_pkg::CH_LF) begin
        // Whitespace is skipped, also between the two digits of a pair.
      end else if (pend_d) begin
        b.res[n] = '{kind: pdfsu_pkg::KIND_DATA, value: {hi_d, hex_value(c)}}; n = n + 2'd1;
        pend_d = 1'b0;
        hi_d   = 4'h0;
      end else begin
        hi_d   = hex_value(c);
        pend_d = 1'b1;
      end
    end

    // The last byte flushes held values and closes an open string.
    if (last_i && (mode_d == pdfsu_pkg::MODE_LIT || mode_d == pdfsu_pkg::MODE_HEX)) begin
      if (mode_d == pdfsu_pkg::MODE_LIT) begin
        if (esc_d == pdfsu_pkg::ESC_OCT1 || esc_d == pdfsu_pkg::ESC_OCT2) begin
          b.res[n] = '{kind: pdfsu_pkg::KIND_DATA, value: oct_d}; n = n + 2'd1;
        end
      end else if (pend_d) begin
        b.res[n] = '{kind: pdfsu_pkg::KIND_DATA, value: {hi_d, 4'h0}}; n = n + 2'd1;
      end
      b.res[n] = '{kind: pdfsu_pkg::KIND_END, value: 8'h00}; n = n + 2'd1;
      mode_d  = pdfsu_pkg::MODE_CLOSED;
      depth_d = '0;
      esc_d   = pdfsu_pkg::ESC_NONE;
      oct_d   = 8'h00;
      hi_d    = 4'h0;
      pend_d  = 1'b0;
    end

    b.cnt    = n;
    bundle_o = b;
    push_o   = accept_i && (n != 2'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= pdfsu_pkg::MODE_CLOSED;
      depth_q <= '0;
      esc_q   <= pdfsu_pkg::ESC_NONE;
      oct_q   <= 8'h00;
      hi_q    <= 4'h0;
      pend_q  <= 1'b0;
    end else if (accept_i) begin
      mode_q  <= mode_d;
      depth_q <= depth_d;
      esc_q   <= esc_d;
      oct_q   <= oct_d;
      hi_q    <= hi_d;
      pend_q  <= pend_d;
    end
  end

endmodule

[src/pdfsu_queue.sv]
// Two-entry queue of result bundles between the front and back ends.
module pdfsu_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  pdfsu_pkg::bundle_t  push_data_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                not_empty_o,
  output pdfsu_pkg::bundle_t  pop_data_o
);

  localparam int unsigned PtrW = $clog2(pdfsu_pkg::QueueDepth);

  pdfsu_pkg::bundle_t   slot_q [pdfsu_pkg::QueueDepth];
  logic [PtrW-1:0]      wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]      rd_ptr_q, rd_ptr_d;
  logic [PtrW:0]        cnt_q, cnt_d;

  assign full_o      = (cnt_q == (PtrW+1)'(pdfsu_pkg::QueueDepth));
  assign not_empty_o = (cnt_q != '0);
  assign pop_data_o  = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + (PtrW+1)'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - (PtrW+1)'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

[src/pdfsu_back.sv]
// Back end: holds one bundle and hands out its results one word at a time.
module pdfsu_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                avail_i,
  input  pdfsu_pkg::bundle_t  bundle_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output pdfsu_pkg::result_t  out_res_o,
  output logic                out_last_o
);

  pdfsu_pkg::bundle_t  cur_q, cur_d;
  logic [1:0]          idx_q, idx_d;
  logic                valid_q, valid_d;
  logic                take;
  logic                load;

  assign out_valid_o = valid_q;
  assign out_res_o   = cur_q.res[idx_q];
  assign out_last_o  = (idx_q == cur_q.cnt - 2'd1);

  assign take  = valid_q && out_ready_i;
  assign load  = !valid_q || (take && out_last_o);
  assign pop_o = load && avail_i;

  always_comb begin
    cur_d   = cur_q;
    idx_d   = idx_q;
    valid_d = valid_q;
    if (load) begin
      valid_d = avail_i;
      cur_d   = bundle_i;
      idx_d   = 2'd0;
    end else if (take) begin
      idx_d = idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 2'd0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

endmodule

[src/pdf_string_unescape_decoder.sv]
// Top level of the PDF string body decoder (literal and hex strings).
// Each result word is registered in the bundle queue and then in the back end.
// One input word per cycle while each causes at most one result and the output does not
// stall; a word with several results holds the single output port until all are taken.
// The two-entry bundle queue lets the front keep taking words while the output stalls.
// Reset: rst_ni clears the parser to closed and empties the queue and output stage.
module pdf_string_unescape_decoder #(
  parameter int unsigned DEPTH_BITS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic [1:0]  s_axis_tuser_i,   // [0] func, [1] first
  input  logic        s_axis_tlast_i,   // last
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // [7:0] out_value
  output logic        m_axis_tuser_o,   // [0] kind
  output logic        m_axis_tlast_o    // run_last
);

  logic                accept;
  logic                push;
  logic                full;
  logic                pop;
  logic                not_empty;
  pdfsu_pkg::bundle_t  push_bundle;
  pdfsu_pkg::bundle_t  head_bundle;
  pdfsu_pkg::result_t  out_res;

  // The front takes a word whenever the queue has room; a word that yields no
  // result (a skipped byte) is taken and simply pushes nothing.
  assign s_axis_tready_o = !full;
  assign accept          = s_axis_tvalid_i && !full;

  pdfsu_front #(
    .DEPTH_BITS(DEPTH_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .data_byte_i(s_axis_tdata_i),
    .func_i     (s_axis_tuser_i[0]),
    .first_i    (s_axis_tuser_i[1]),
    .last_i     (s_axis_tlast_i),
    .push_o     (push),
    .bundle_o   (push_bundle)
  );

  pdfsu_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_bundle),
    .full_o     (full),
    .pop_i      (pop),
    .not_empty_o(not_empty),
    .pop_data_o (head_bundle)
  );

  // The back end holds the bundle being sent and steps through its results.
  pdfsu_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .avail_i    (not_empty),
    .bundle_i   (head_bundle),
    .pop_o      (pop),
    .out_valid_o(m_axis_tvalid_o),
    .out_ready_i(m_axis_tready_i),
    .out_res_o  (out_res),
    .out_last_o (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = out_res.value;
  assign m_axis_tuser_o = out_res.kind;

endmodule

[sim/pdfsu_checker.sv]
// Scoreboard for the PDF string decoder: predicts decoded words and checks the output stream.
`timescale 1ns / 1ps

module pdfsu_checker #(
  parameter int unsigned DEPTH_BITS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic [1:0]  s_axis_tuser_i,   // [0] func, [1] first
  input  logic        s_axis_tlast_i,   // last
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  input  logic [7:0]  m_axis_tdata_i,   // [7:0] out_value
  input  logic        m_axis_tuser_i,   // [0] kind
  input  logic        m_axis_tlast_i,   // run_last
  output int unsigned outstanding_o,
  output int unsigned mismatches_o
);

  localparam logic [DEPTH_BITS-1:0] DepthMax = '1;

  typedef struct packed {
    pdfsu_pkg::kind_e kind;
    logic [7:0]       value;
    logic             tail;
  } dec_word_t;

  pdfsu_pkg::mode_e      mode;
  logic [DEPTH_BITS-1:0] depth;
  pdfsu_pkg::esc_e       esc;
  logic [7:0]            oct;
  logic [3:0]            hi_nib;
  logic                  nib_held;

  dec_word_t   expected_q[$];
  dec_word_t   step_q[$];
  int unsigned mismatches = 0;

  assign mismatches_o = mismatches;

  function automatic void clear_parser();
    mode     = pdfsu_pkg::MODE_CLOSED;
    depth    = '0;
    esc      = pdfsu_pkg::ESC_NONE;
    oct      = 8'h00;
    hi_nib   = 4'h0;
    nib_held = 1'b0;
  endfunction

  function automatic void put(pdfsu_pkg::kind_e k, logic [7:0] v);
    dec_word_t w;
    w.kind  = k;
    w.value = (k == pdfsu_pkg::KIND_END) ? 8'h00 : v;
    w.tail  = 1'b0;
    step_q.push_back(w);
  endfunction

  function automatic logic is_oct(logic [7:0] c);
    return (c >= pdfsu_pkg::CH_ZERO) && (c <= pdfsu_pkg::CH_SEVEN);
  endfunction

  function automatic logic [3:0] nib_value(logic [7:0] c);
    logic [7:0] t;
    t = 8'h00;
    if (c >= pdfsu_pkg::CH_ZERO && c <= pdfsu_pkg::CH_NINE) begin
      t = c - pdfsu_pkg::CH_ZERO;
    end else if (c >= pdfsu_pkg::CH_UA && c <= pdfsu_pkg::CH_UF) begin
      t = c - pdfsu_pkg::CH_UA + 8'd10;
    end else if (c >= pdfsu_pkg::CH_LA && c <= pdfsu_pkg::CH_LF_) begin
      t = c - pdfsu_pkg::CH_LA + 8'd10;
    end
    return t[3:0];
  endfunction

  // A literal byte outside any escape.
  function automatic void plain_char(logic [7:0] c);
    if (c == pdfsu_pkg::CH_BSL) begin
      esc = pdfsu_pkg::ESC_BSL;
    end else if (c == pdfsu_pkg::CH_LPAREN) begin
      if (depth != DepthMax) depth++;
      put(pdfsu_pkg::KIND_DATA, pdfsu_pkg::CH_LPAREN);
    end else if (c == pdfsu_pkg::CH_RPAREN) begin
      if (depth != '0) depth--;
      if (depth != '0) begin
        put(pdfsu_pkg::KIND_DATA, pdfsu_pkg::CH_RPAREN);
      end else begin
        put(pdfsu_pkg::KIND_END, 8'h00);
        clear_parser();
      end
    end else begin
      put(pdfsu_pkg::KIND_DATA, c);
    end
  endfunction

  function automatic void literal_char(logic [7:0] c);
    case (esc)
      pdfsu_pkg::ESC_BSL: begin
        esc = pdfsu_pkg::ESC_NONE;
        case (c)
          pdfsu_pkg::CH_N:   put(pdfsu_pkg::KIND_DATA, pdfsu_pkg::CH_LF);
          pdfsu_pkg::CH_R:   put(pdfsu_pkg::KIND_DATA, pdfsu_pkg::CH_CR);
          pdfsu_pkg::CH_T:   put(pdfsu_pkg::KIND_DATA, pdfsu_pkg::CH_TAB);
          pdfsu_pkg::CH_B:   put(pdfsu_pkg::KIND_DATA, pdfsu_pkg::CH_BS);
          pdfsu_pkg::CH_LF_: put(pdfsu_pkg::KIND_DATA, pdfsu_pkg::CH_FF);
          pdfsu_pkg::CH_LF:  ;
          pdfsu_pkg::CH_CR:  esc = pdfsu_pkg::ESC_CR;
          default: begin
            if (is_oct(c)) begin
              oct = {5'd0, c[2:0]};
              esc = pdfsu_pkg::ESC_OCT1;
            end else begin
              put(pdfsu_pkg::KIND_DATA, c);
            end
          end
        endcase
      end
      pdfsu_pkg::ESC_CR: begin
        esc = pdfsu_pkg::ESC_NONE;
        if (c != pdfsu_pkg::CH_LF) plain_char(c);
      end
      pdfsu_pkg::ESC_OCT1, pdfsu_pkg::ESC_OCT2: begin
        if (is_oct(c)) begin
          oct = {oct[4:0], 3'b000} + {5'd0, c[2:0]};
          if (esc == pdfsu_pkg::ESC_OCT1) begin
            esc = pdfsu_pkg::ESC_OCT2;
          end else begin
            esc = pdfsu_pkg::ESC_NONE;
            put(pdfsu_pkg::KIND_DATA, oct);
          end
        end else begin
          esc = pdfsu_pkg::ESC_NONE;
          put(pdfsu_pkg::KIND_DATA, oct);
          plain_char(c);
        end
      end
      default: begin
        esc = pdfsu_pkg::ESC_NONE;
        plain_char(c);
      end
    endcase
  endfunction

  function automatic void hex_char(logic [7:0] c);
    if (c == pdfsu_pkg::CH_GT) begin
      if (nib_held) put(pdfsu_pkg::KIND_DATA, {hi_nib, 4'h0});
      put(pdfsu_pkg::KIND_END, 8'h00);
      clear_parser();
    end else if (c == pdfsu_pkg::CH_SPACE || c == pdfsu_pkg::CH_TAB ||
                 c == pdfsu_pkg::CH_CR || c == pdfsu_pkg::CH_LF) begin
      // Whitespace is skipped, also between the two digits of a pair.
    end else if (nib_held) begin
      put(pdfsu_pkg::KIND_DATA, {hi_nib, nib_value(c)});
      nib_held = 1'b0;
      hi_nib   = 4'h0;
    end else begin
      hi_nib   = nib_value(c);
      nib_held = 1'b1;
    end
  endfunction

  // Works out every decoded word that one accepted input word causes.
  function automatic void decode_input(logic [7:0] c, logic fn, logic fst, logic lst);
    step_q.delete();
    if (fst) begin
      clear_parser();
      if (fn) begin
        mode = pdfsu_pkg::MODE_HEX;
      end else begin
        mode  = pdfsu_pkg::MODE_LIT;
        depth = DEPTH_BITS'(1);
      end
    end
    if (mode == pdfsu_pkg::MODE_LIT) literal_char(c);
    else if (mode == pdfsu_pkg::MODE_HEX) hex_char(c);
    if (lst && (mode == pdfsu_pkg::MODE_LIT || mode == pdfsu_pkg::MODE_HEX)) begin
      if (mode == pdfsu_pkg::MODE_LIT) begin
        if (esc == pdfsu_pkg::ESC_OCT1 || esc == pdfsu_pkg::ESC_OCT2) begin
          put(pdfsu_pkg::KIND_DATA, oct);
        end
      end else if (nib_held) begin
        put(pdfsu_pkg::KIND_DATA, {hi_nib, 4'h0});
      end
      put(pdfsu_pkg::KIND_END, 8'h00);
      clear_parser();
    end
    if (step_q.size() > 0) step_q[step_q.size()-1].tail = 1'b1;
    foreach (step_q[i]) expected_q.push_back(step_q[i]);
  endfunction

  task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
    $display("[%0t] mismatch: %s, got %0h, expected %0h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic check_output();
    dec_word_t want;
    if (expected_q.size() == 0) begin
      report_mismatch("output word with nothing expected", m_axis_tdata_i, 8'h00);
    end else begin
      want = expected_q.pop_front();
      if (m_axis_tuser_i != want.kind)
        report_mismatch("kind", {7'd0, m_axis_tuser_i}, {7'd0, want.kind});
      if (m_axis_tdata_i != want.value)
        report_mismatch("out_value", m_axis_tdata_i, want.value);
      if (m_axis_tlast_i != want.tail)
        report_mismatch("run_last", {7'd0, m_axis_tlast_i}, {7'd0, want.tail});
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_parser();
      expected_q.delete();
      outstanding_o <= 0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_i)
        decode_input(s_axis_tdata_i, s_axis_tuser_i[0], s_axis_tuser_i[1], s_axis_tlast_i);
      if (m_axis_tvalid_i && m_axis_tready_i) check_output();
      outstanding_o <= expected_q.size();
    end
  end

endmodule

[sim/tb_top.sv]
// Testbench top for the PDF string decoder: clock, reset, stimulus and the final verdict.
`timescale 1ns / 1ps

module tb_top;

  // A two-bit nesting counter lets a handful of open parentheses reach saturation, so the
  // deep nesting case is hit both in the directed part and often in the random strings.
  localparam int unsigned DepthBits = 2;

  // String kinds as carried in bit 0 of the input tuser.
  localparam logic FUNC_LIT = 1'b0;
  localparam logic FUNC_HEX = 1'b1;

  // Random input words wanted in each phase.
  localparam int unsigned PhaseWords = 15;

  logic        clk_i;
  logic        rst_n = 1'b0;

  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata  = 8'h00;
  logic [1:0]  s_tuser  = 2'b00;
  logic        s_tlast  = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b1;
  logic [7:0]  m_tdata;
  logic        m_tuser;
  logic        m_tlast;

  int unsigned idle_pct  = 0;
  int unsigned stall_pct = 0;
  int unsigned outstanding;
  int unsigned mismatches;

  int unsigned idle_set[4]  = '{0, 73, 0, 32};
  int unsigned stall_set[4] = '{0, 0, 73, 32};

  pdf_string_unescape_decoder #(
    .DEPTH_BITS(DepthBits)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_n),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tuser_i (s_tuser),
    .s_axis_tlast_i (s_tlast),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata),
    .m_axis_tuser_o (m_tuser),
    .m_axis_tlast_o (m_tlast)
  );

  pdfsu_checker #(
    .DEPTH_BITS(DepthBits)
  ) u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_n),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_i(s_tready),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tuser_i (s_tuser),
    .s_axis_tlast_i (s_tlast),
    .m_axis_tvalid_i(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_i (m_tdata),
    .m_axis_tuser_i (m_tuser),
    .m_axis_tlast_i (m_tlast),
    .outstanding_o  (outstanding),
    .mismatches_o   (mismatches)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // The receiver drops its ready at random according to the stall rate of the current phase.
  always @(posedge clk_i) begin
    m_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Offers one word and returns at the rising edge where it is taken. Ready is read at the
  // falling edge, where it has settled, so the handshake does not hinge on event ordering.
  task automatic send_word(logic [7:0] b, logic fn, logic fst, logic lst);
    logic taken;
    while ($urandom_range(0, 99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tuser  <= {fst, fn};
    s_tlast  <= lst;
    do begin
      @(negedge clk_i);
      taken = s_tready;
      @(posedge clk_i);
    end while (!taken);
  endtask

  // Sends a whole string body. Every word after the first carries the other kind, which the
  // block must ignore once the string is open.
  task automatic send_text(string s, logic fn, logic close_on_end);
    for (int i = 0; i < s.len(); i++)
      send_word(s[i], (i == 0) ? fn : !fn, i == 0, close_on_end && (i == s.len() - 1));
  endtask

  // Holds the input back until every predicted word has come out. The first edge lets the
  // checker count the word that was accepted just now.
  task automatic wait_for_results();
    s_tvalid <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
  endtask

  // Literal bodies lean on backslashes, parentheses, octal digits and line ends, so that
  // escapes and nesting are reached often; the rest is any byte at all.
  function automatic logic [7:0] pick_literal_byte();
    logic [7:0] b;
    case ($urandom_range(0, 11))
      0, 1: b = pdfsu_pkg::CH_BSL;
      2, 3: b = pdfsu_pkg::CH_LPAREN;
      4:    b = pdfsu_pkg::CH_RPAREN;
      5, 6: b = pdfsu_pkg::CH_ZERO + 8'($urandom_range(0, 7));
      7: begin
        case ($urandom_range(0, 4))
          0:       b = pdfsu_pkg::CH_N;
          1:       b = pdfsu_pkg::CH_R;
          2:       b = pdfsu_pkg::CH_T;
          3:       b = pdfsu_pkg::CH_B;
          default: b = pdfsu_pkg::CH_LF_;
        endcase
      end
      8:       b = $urandom_range(0, 1) ? pdfsu_pkg::CH_CR : pdfsu_pkg::CH_LF;
      default: b = 8'($urandom_range(0, 255));
    endcase
    return b;
  endfunction

  // Hex bodies are mostly valid digits of either case, with whitespace, the odd closing
  // bracket and the odd stray byte mixed in.
  function automatic logic [7:0] pick_hex_byte();
    logic [7:0] b;
    int unsigned r;
    r = $urandom_range(0, 21);
    case ($urandom_range(0, 15))
      0, 1, 2, 3, 4, 5, 6, 7: begin
        if (r < 10) b = pdfsu_pkg::CH_ZERO + 8'(r);
        else if (r < 16) b = pdfsu_pkg::CH_UA + 8'(r - 10);
        else b = pdfsu_pkg::CH_LA + 8'(r - 16);
      end
      8, 9, 10: begin
        case (r % 4)
          0:       b = pdfsu_pkg::CH_SPACE;
          1:       b = pdfsu_pkg::CH_TAB;
          2:       b = pdfsu_pkg::CH_CR;
          default: b = pdfsu_pkg::CH_LF;
        endcase
      end
      11:      b = pdfsu_pkg::CH_GT;
      default: b = 8'($urandom_range(0, 255));
    endcase
    return b;
  endfunction

  // A well formed string of random content. It usually closes with last on its final word;
  // otherwise it may be left open and the next string restarts the parser with first.
  task automatic send_random_string(inout int unsigned words);
    int unsigned len;
    logic        fn;
    logic [7:0]  b;
    logic        lst;
    fn  = 1'($urandom_range(0, 1));
    len = $urandom_range(1, 14);
    for (int i = 0; i < len; i++) begin
      b   = (fn == FUNC_HEX) ? pick_hex_byte() : pick_literal_byte();
      lst = (i == len - 1) ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 19) == 0);
      send_word(b, (i == 0) ? fn : 1'($urandom_range(0, 1)), i == 0, lst);
      words++;
    end
    // Stray words after the string, which a closed parser must drop.
    if ($urandom_range(0, 4) == 0)
      send_word(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0,
                1'($urandom_range(0, 1)));
  endtask

  initial begin
    int unsigned words;
    repeat (2) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    for (int phase = 0; phase < 4; phase++) begin
      idle_pct  = idle_set[phase];
      stall_pct = stall_set[phase];
      if (phase == 0) begin
        // A word before any string is open is dropped, even with last set.
        send_word(8'hFF, FUNC_HEX, 1'b0, 1'b1);
        // Three digit octal, octal cut short by a letter, and an escaped closing paren.
        send_text("\\101\\7z\\)", FUNC_LIT, 1'b0);
        // Restart while open, nesting past saturation, backslash-CR followed by a plain
        // byte, backslash-CRLF, backslash-LF, and last arriving with one octal digit held.
        send_text("((()\\\015a\\\015\n\\\n\\5", FUNC_LIT, 1'b1);
        // Last arriving on a lone backslash, then on a backslash-CR: neither gives data.
        send_text("\\", FUNC_LIT, 1'b1);
        send_text("\\\015", FUNC_LIT, 1'b1);
        // Space between the digits of a pair, an invalid digit, then the closing bracket
        // with a nibble still held.
        send_text("A f\tG>", FUNC_HEX, 1'b0);
        // A zero data byte, then the closing paren at the outermost level.
        send_word(8'h00, FUNC_LIT, 1'b1, 1'b0);
        send_word(pdfsu_pkg::CH_RPAREN, FUNC_HEX, 1'b0, 1'b0);
        // An odd hex string closed by last is padded with a zero nibble.
        send_word(pdfsu_pkg::CH_NINE, FUNC_HEX, 1'b1, 1'b1);
        wait_for_results();
      end
      words = 0;
      while (words < PhaseWords) send_random_string(words);
      wait_for_results();
    end

    // Everything has come out; keep the clock running so that any stray word reaches the checker.
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Guard against a hang in the handshake or a lost result.
  initial begin
    #200_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

[filelist.f]
src/pdfsu_pkg.sv
src/pdfsu_front.sv
src/pdfsu_queue.sv
src/pdfsu_back.sv
src/pdf_string_unescape_decoder.sv
sim/pdfsu_checker.sv
sim/tb_top.sv
